/* rtl/fixed_point_alu_q24_8_top_assert.svh */
// Assertion macros for the fixed-point ALU modules; fpa_queue includes this header.
// Each macro expects a clock named i_clk and an active-low reset i_rst_n in scope.
`ifndef FIXED_POINT_ALU_Q24_8_TOP_ASSERT_SVH
`define FIXED_POINT_ALU_Q24_8_TOP_ASSERT_SVH

// The condition must hold at every clock edge outside reset.
`define FPA_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);

// When the trigger holds, the consequence must hold in the next cycle.
`define FPA_ASSERT_NEXT(lbl, trig, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (trig) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/fpa_pkg.sv */
// Shared operation codes and the control word of the fixed-point ALU.
// No dependencies; used by the front, queue, back and top modules.
package fpa_pkg;

    localparam int KIND_W = 5;
    localparam int PORT_W = 32;

    localparam logic [KIND_W-1:0] OP_ADD      = 5'd0;
    localparam logic [KIND_W-1:0] OP_SUB      = 5'd1;
    localparam logic [KIND_W-1:0] OP_MUL      = 5'd2;
    localparam logic [KIND_W-1:0] OP_DIV      = 5'd3;
    localparam logic [KIND_W-1:0] OP_REM      = 5'd4;
    localparam logic [KIND_W-1:0] OP_EQ       = 5'd5;
    localparam logic [KIND_W-1:0] OP_NE       = 5'd6;
    localparam logic [KIND_W-1:0] OP_LT       = 5'd7;
    localparam logic [KIND_W-1:0] OP_GT       = 5'd8;
    localparam logic [KIND_W-1:0] OP_LE       = 5'd9;
    localparam logic [KIND_W-1:0] OP_GE       = 5'd10;
    localparam logic [KIND_W-1:0] OP_INC      = 5'd11;
    localparam logic [KIND_W-1:0] OP_DEC      = 5'd12;
    localparam logic [KIND_W-1:0] OP_MIN      = 5'd13;
    localparam logic [KIND_W-1:0] OP_MAX      = 5'd14;
    localparam logic [KIND_W-1:0] OP_FROM_INT = 5'd15;
    localparam logic [KIND_W-1:0] OP_TO_INT   = 5'd16;

    // Classification made by the front end for each item.
    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic              div_op;  // divide or remainder
        logic              rem_op;  // remainder only
        logic              b_zero;  // divisor is zero
    } t_ctl;

endpackage

/* rtl/fpa_front.sv */
// Front end of the fixed-point ALU: accepts items and classifies the operation.
// Depends on fpa_pkg.
module fpa_front #(
    parameter int DATA_WIDTH = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [fpa_pkg::KIND_W-1:0]    i_kind,
    input  logic [DATA_WIDTH-1:0]         i_a,
    input  logic [DATA_WIDTH-1:0]         i_b,
    output logic                          o_push,
    input  logic                          i_full,
    output fpa_pkg::t_ctl                 o_ctl,
    output logic [DATA_WIDTH-1:0]         o_a,
    output logic [DATA_WIDTH-1:0]         o_b
);

    logic                  r_vld;
    fpa_pkg::t_ctl         r_ctl;
    logic [DATA_WIDTH-1:0] r_a;
    logic [DATA_WIDTH-1:0] r_b;
    fpa_pkg::t_ctl         n_ctl;
    logic                  load;

    assign o_ready = !r_vld || !i_full;
    assign load    = i_valid && o_ready;
    assign o_push  = r_vld && !i_full;

    always_comb begin
        n_ctl.kind   = i_kind;
        n_ctl.div_op = (i_kind == fpa_pkg::OP_DIV) || (i_kind == fpa_pkg::OP_REM);
        n_ctl.rem_op = (i_kind == fpa_pkg::OP_REM);
        n_ctl.b_zero = (i_b == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (load) begin
            r_vld <= 1'b1;
        end else if (o_push) begin
            r_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_ctl <= n_ctl;
            r_a   <= i_a;
            r_b   <= i_b;
        end
    end

    assign o_ctl = r_ctl;
    assign o_a   = r_a;
    assign o_b   = r_b;

endmodule

/* rtl/fpa_queue.sv */
// Short register queue that decouples the ALU front end from its back end.
// Depends on fpa_pkg and the assertion macro header.
`include "fixed_point_alu_q24_8_top_assert.svh"

module fpa_queue #(
    parameter int DATA_WIDTH = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    output logic                  o_full,
    input  fpa_pkg::t_ctl         i_ctl,
    input  logic [DATA_WIDTH-1:0] i_a,
    input  logic [DATA_WIDTH-1:0] i_b,
    output logic                  o_valid,
    input  logic                  i_pop,
    output fpa_pkg::t_ctl         o_ctl,
    output logic [DATA_WIDTH-1:0] o_a,
    output logic [DATA_WIDTH-1:0] o_b
);

    localparam int DEPTH = 4;
    localparam int PTR_W = $clog2(DEPTH);

    fpa_pkg::t_ctl         r_ctl [DEPTH];
    logic [DATA_WIDTH-1:0] r_a   [DEPTH];
    logic [DATA_WIDTH-1:0] r_b   [DEPTH];
    logic [PTR_W-1:0]      r_wr;
    logic [PTR_W-1:0]      r_rd;
    logic [PTR_W:0]        r_cnt;
    logic                  do_pop;

    assign o_full  = (r_cnt == (PTR_W+1)'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (i_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_ctl[r_wr] <= i_ctl;
            r_a[r_wr]   <= i_a;
            r_b[r_wr]   <= i_b;
        end
    end

    assign o_ctl = r_ctl[r_rd];
    assign o_a   = r_a[r_rd];
    assign o_b   = r_b[r_rd];

    `FPA_ASSERT_ALWAYS(a_cnt_bound, r_cnt <= (PTR_W+1)'(DEPTH), "queue count exceeds depth")
    `FPA_ASSERT_ALWAYS(a_no_overflow, !(i_push && o_full), "push into a full queue")
    `FPA_ASSERT_NEXT(a_push_grows, i_push && !do_pop, r_cnt == $past(r_cnt) + 1'b1,
        "queue count did not grow on push")

endmodule

/* rtl/fpa_back.sv */
// Back end of the fixed-point ALU: operand setup, multiplier, one-bit-per-stage
// divider pipeline and result register. Depends on fpa_pkg.
module fpa_back #(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 8
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  fpa_pkg::t_ctl               i_ctl,
    input  logic [DATA_WIDTH-1:0]       i_a,
    input  logic [DATA_WIDTH-1:0]       i_b,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [fpa_pkg::PORT_W-1:0]  o_value,
    output logic                        o_cmp,
    output logic                        o_dz
);

    localparam int DW = DATA_WIDTH;
    localparam int QW = DATA_WIDTH + FRAC_BITS;  // dividend and quotient width
    localparam int NS = QW;                      // divider stages

    logic en;

    // Stage arrays: index 0 is operand setup, 1..NS are divider steps.
    logic                 r_vld  [0:NS];
    fpa_pkg::t_ctl        r_ctl  [0:NS];
    logic [DW-1:0]        r_res  [0:NS];
    logic                 r_cmp  [0:NS];
    logic [DW-1:0]        r_rem  [0:NS];
    logic [QW-1:0]        r_dvd  [0:NS];
    logic [DW-1:0]        r_dvs  [0:NS];
    logic                 r_qneg [0:NS];
    logic                 r_rneg [0:NS];
    logic signed [2*DW-1:0] r_prod;

    logic                 r_out_vld;
    logic [fpa_pkg::PORT_W-1:0] r_out_val;
    logic                 r_out_cmp;
    logic                 r_out_dz;

    logic signed [DW-1:0] sa;
    logic signed [DW-1:0] sb;
    logic [DW-1:0]        abs_a;
    logic [DW-1:0]        abs_b;
    logic [DW-1:0]        n_res;
    logic                 n_cmp;
    logic [QW-1:0]        n_dvd;

    assign en      = !r_out_vld || i_ready;
    assign o_ready = en;

    assign sa    = signed'(i_a);
    assign sb    = signed'(i_b);
    assign abs_a = sa[DW-1] ? DW'(-sa) : i_a;
    assign abs_b = sb[DW-1] ? DW'(-sb) : i_b;
    assign n_dvd = i_ctl.rem_op ? QW'(abs_a) : {abs_a, {FRAC_BITS{1'b0}}};

    always_comb begin
        n_res = '0;
        n_cmp = 1'b0;
        case (i_ctl.kind)
            fpa_pkg::OP_ADD:      n_res = DW'(sa + sb);
            fpa_pkg::OP_SUB:      n_res = DW'(sa - sb);
            fpa_pkg::OP_INC:      n_res = DW'(sa + 1'b1);
            fpa_pkg::OP_DEC:      n_res = DW'(sa - 1'b1);
            fpa_pkg::OP_MIN:      n_res = (sa > sb) ? i_b : i_a;
            fpa_pkg::OP_MAX:      n_res = (sa > sb) ? i_a : i_b;
            fpa_pkg::OP_FROM_INT: n_res = DW'(i_a << FRAC_BITS);
            fpa_pkg::OP_TO_INT:   n_res = DW'(sa >>> FRAC_BITS);
            fpa_pkg::OP_EQ:       n_cmp = (sa == sb);
            fpa_pkg::OP_NE:       n_cmp = (sa != sb);
            fpa_pkg::OP_LT:       n_cmp = (sa < sb);
            fpa_pkg::OP_GT:       n_cmp = (sa > sb);
            fpa_pkg::OP_LE:       n_cmp = (sa <= sb);
            fpa_pkg::OP_GE:       n_cmp = (sa >= sb);
            default:              n_res = '0;
        endcase
    end

    // Setup stage: simple results, the full product and divider operands.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (en) begin
            r_vld[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ctl[0]  <= i_ctl;
            r_res[0]  <= n_res;
            r_cmp[0]  <= n_cmp;
            r_prod    <= sa * sb;
            r_rem[0]  <= '0;
            r_dvd[0]  <= n_dvd;
            r_dvs[0]  <= abs_b;
            r_qneg[0] <= sa[DW-1] ^ sb[DW-1];
            r_rneg[0] <= sa[DW-1];
        end
    end

    // Restoring divider, one quotient bit per stage; quotient bits shift into
    // the dividend register as its bits are consumed.
    for (genvar k = 1; k <= NS; k++) begin : g_div
        logic [DW:0]   trial;
        logic [DW:0]   diff;
        logic          ge;
        logic [DW-1:0] res_in;

        assign trial = {r_rem[k-1], r_dvd[k-1][QW-1]};
        assign diff  = trial - {1'b0, r_dvs[k-1]};
        assign ge    = (trial >= {1'b0, r_dvs[k-1]});

        if (k == 1) begin : g_mul
            // The product is folded into the result here, after its register.
            assign res_in = (r_ctl[0].kind == fpa_pkg::OP_MUL) ?
                            r_prod[FRAC_BITS +: DW] : r_res[0];
        end else begin : g_pass
            assign res_in = r_res[k-1];
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (en) begin
                r_vld[k] <= r_vld[k-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_ctl[k]  <= r_ctl[k-1];
                r_res[k]  <= res_in;
                r_cmp[k]  <= r_cmp[k-1];
                r_rem[k]  <= ge ? diff[DW-1:0] : trial[DW-1:0];
                r_dvd[k]  <= {r_dvd[k-1][QW-2:0], ge};
                r_dvs[k]  <= r_dvs[k-1];
                r_qneg[k] <= r_qneg[k-1];
                r_rneg[k] <= r_rneg[k-1];
            end
        end
    end

    // Sign correction and final selection.
    logic [QW-1:0]        quo;
    logic [DW-1:0]        rem;
    logic signed [DW-1:0] n_val;

    assign quo = r_qneg[NS] ? QW'(-r_dvd[NS]) : r_dvd[NS];
    assign rem = r_rneg[NS] ? DW'(-r_rem[NS]) : r_rem[NS];

    always_comb begin
        if (r_ctl[NS].div_op) begin
            if (r_ctl[NS].b_zero) begin
                n_val = '0;
            end else if (r_ctl[NS].rem_op) begin
                n_val = signed'(rem);
            end else begin
                n_val = signed'(quo[DW-1:0]);
            end
        end else begin
            n_val = signed'(r_res[NS]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_out_vld <= r_vld[NS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_val <= fpa_pkg::PORT_W'(n_val);
            r_out_cmp <= r_cmp[NS];
            r_out_dz  <= r_ctl[NS].div_op && r_ctl[NS].b_zero;
        end
    end

    assign o_valid = r_out_vld;
    assign o_value = r_out_val;
    assign o_cmp   = r_out_cmp;
    assign o_dz    = r_out_dz;

endmodule

/* rtl/fixed_point_alu_q24_8_top.sv */
// Top level of the signed fixed-point ALU (Q24.8 by default).
// Depends on fpa_pkg, fpa_front, fpa_queue and fpa_back.
//
// Usage:
//   Input stream (s side): tuser carries the operation kind, tdata carries
//   operand_a in bits [31:0] and operand_b in bits [63:32]. An item is taken
//   at a clock edge where i_s_tvalid and o_s_tready are both high.
//   Output stream (m side): tdata carries result_value, tuser bit 0 is
//   compare_true and bit 1 is divide_by_zero. Exactly one result item comes
//   out for each input item, in order.
//   An item passes through one front register, one queue slot, one setup
//   stage holding the multiplier, one stage per quotient bit of the divider,
//   and the output register.
//   Every operation goes through the same pipeline, so results never reorder.
//   Throughput is one item per cycle while the receiver accepts results; the
//   divider is fully pipelined with one bit per stage, which sets the depth.
//   Reset (synchronous, active low) empties the front register, the queue and
//   all pipeline stages; no result is pending afterwards.
//   When the receiver stalls, the back pipeline holds in place; the four-entry
//   queue and the front register keep accepting items until they fill, after
//   which o_s_tready drops.
module fixed_point_alu_q24_8_top #(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [63:0] i_s_tdata,   // [31:0] operand_a, [63:32] operand_b
    input  logic [4:0]  i_s_tuser,   // [4:0] kind
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata,   // [31:0] result_value
    output logic [1:0]  o_m_tuser    // [0] compare_true, [1] divide_by_zero
);

    // Front end to queue.
    logic                  f_push;
    logic                  q_full;
    fpa_pkg::t_ctl         f_ctl;
    logic [DATA_WIDTH-1:0] f_a;
    logic [DATA_WIDTH-1:0] f_b;

    // Queue to back end.
    logic                  q_valid;
    logic                  b_ready;
    fpa_pkg::t_ctl         q_ctl;
    logic [DATA_WIDTH-1:0] q_a;
    logic [DATA_WIDTH-1:0] q_b;

    logic                  cmp;
    logic                  dz;

    // Only the low DATA_WIDTH bits of each operand take part.
    fpa_front #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_tvalid),
        .o_ready (o_s_tready),
        .i_kind  (i_s_tuser),
        .i_a     (i_s_tdata[DATA_WIDTH-1:0]),
        .i_b     (i_s_tdata[32 +: DATA_WIDTH]),
        .o_push  (f_push),
        .i_full  (q_full),
        .o_ctl   (f_ctl),
        .o_a     (f_a),
        .o_b     (f_b)
    );

    fpa_queue #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_push),
        .o_full  (q_full),
        .i_ctl   (f_ctl),
        .i_a     (f_a),
        .i_b     (f_b),
        .o_valid (q_valid),
        .i_pop   (b_ready),
        .o_ctl   (q_ctl),
        .o_a     (q_a),
        .o_b     (q_b)
    );

    fpa_back #(
        .DATA_WIDTH (DATA_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .o_ready (b_ready),
        .i_ctl   (q_ctl),
        .i_a     (q_a),
        .i_b     (q_b),
        .o_valid (o_m_tvalid),
        .i_ready (i_m_tready),
        .o_value (o_m_tdata),
        .o_cmp   (cmp),
        .o_dz    (dz)
    );

    assign o_m_tuser = {dz, cmp};

endmodule
